[src/ahgc_pkg.sv]
package ahgc_pkg;

  // Coefficient format: signed Q(32-F).F
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_W         = 32;
  localparam int SAMPLE_W       = 16;
  localparam int VOL_W          = 7;
  localparam int GAIN_W         = 9;

  // Output history: 40 bits, 16 fraction bits
  localparam int HIST_W         = 40;
  localparam int HIST_FRAC      = 16;

  // APB register window: six 32-bit registers
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  // Reset value of b0 is 1.0
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic [VOL_W-1:0]         VOL_RESET = VOL_W'(85);

  // volume*256/100 = volume*64/25, done as a multiply by ceil(2^20/25)
  localparam int GAIN_RECIP_SHIFT = 20;
  localparam int GAIN_RECIP       = ((1 << GAIN_RECIP_SHIFT) + 24) / 25;
  localparam int GAIN_PROD_W      = 23;

  typedef enum logic [2:0] {
    REG_COEF_B0  = 3'd0,
    REG_COEF_B1  = 3'd1,
    REG_COEF_A1  = 3'd2,
    REG_COEF_A2  = 3'd3,
    REG_VOLUME   = 3'd4,
    REG_STEREO   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic [VOL_W-1:0]         volume_pct;
    logic                     source_stereo;
  } cfg_t;

  // Gain = floor(volume * 256 / 100), exact for every 7-bit volume
  function automatic logic [GAIN_W-1:0] gain_of(input logic [VOL_W-1:0] vol);
    logic [GAIN_PROD_W-1:0] prod;
    prod = GAIN_PROD_W'(vol) * GAIN_PROD_W'(GAIN_RECIP);
    return prod[GAIN_PROD_W-1 -: GAIN_W];
  endfunction

endpackage

[src/ahgc_regs.sv]
module ahgc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ahgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ahgc_pkg::DATA_W-1:0]  pwdata,
  output logic [ahgc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ahgc_pkg::cfg_t               cfg_o
);
  import ahgc_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register, ignore holes in the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_b0       <= COEF_ONE;
      cfg_q.coef_b1       <= '0;
      cfg_q.coef_a1       <= '0;
      cfg_q.coef_a2       <= '0;
      cfg_q.volume_pct    <= VOL_RESET;
      cfg_q.source_stereo <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COEF_B0: cfg_q.coef_b0       <= pwdata;
        REG_COEF_B1: cfg_q.coef_b1       <= pwdata;
        REG_COEF_A1: cfg_q.coef_a1       <= pwdata;
        REG_COEF_A2: cfg_q.coef_a2       <= pwdata;
        REG_VOLUME:  cfg_q.volume_pct    <= pwdata[VOL_W-1:0];
        REG_STEREO:  cfg_q.source_stereo <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_COEF_B0: prdata = cfg_q.coef_b0;
      REG_COEF_B1: prdata = cfg_q.coef_b1;
      REG_COEF_A1: prdata = cfg_q.coef_a1;
      REG_COEF_A2: prdata = cfg_q.coef_a2;
      REG_VOLUME:  prdata = DATA_W'(cfg_q.volume_pct);
      REG_STEREO:  prdata = DATA_W'(cfg_q.source_stereo);
      default:     prdata = '0;
    endcase
  end

endmodule

[src/audio_highpass_gain_clamp_core.sv]
// Each item passes ST_MAC, ST_CONV, ST_TRUNC, ST_GAIN and ST_SCALE before
// speaker_sample_o is valid. A new item is taken only in ST_IDLE; a single
// shared 32x25 multiplier runs the seven biquad products and the gain product.
// in_stall_o is high from acceptance until the result enters the output register.
// Reset (rst_ni low, asynchronous) clears control, filter history and loads
// the register defaults (b0 = 1.0, volume 85, mono source).
module audio_highpass_gain_clamp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ahgc_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [ahgc_pkg::SAMPLE_W-1:0] right_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ahgc_pkg::SAMPLE_W-1:0] speaker_sample_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ahgc_pkg::ADDR_W-1:0]     paddr,
  input  logic [ahgc_pkg::DATA_W-1:0]     pwdata,
  output logic [ahgc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import ahgc_pkg::*;

  localparam int MUL_B_W = 25;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int ACC_W   = 60;
  localparam int WIDE_W  = 64;
  localparam int YI_W    = HIST_W - HIST_FRAC;
  localparam int SHR     = (COEF_FRAC_BITS >= HIST_FRAC) ? COEF_FRAC_BITS - HIST_FRAC : 0;
  localparam int SHL     = (COEF_FRAC_BITS >= HIST_FRAC) ? 0 : HIST_FRAC - COEF_FRAC_BITS;

  localparam logic signed [WIDE_W-1:0] HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] HIST_MIN = -(64'sd1 <<< (HIST_W - 1));
  localparam logic signed [PROD_W-1:0] SAMP_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAMP_MIN = -PROD_W'(32768);

  // Multiply sequence of the filter
  localparam logic [2:0] STEP_B0_X   = 3'd0;
  localparam logic [2:0] STEP_B1_X1  = 3'd1;
  localparam logic [2:0] STEP_B0_X2  = 3'd2;
  localparam logic [2:0] STEP_A1_HI  = 3'd3;
  localparam logic [2:0] STEP_A1_LO  = 3'd4;
  localparam logic [2:0] STEP_A2_HI  = 3'd5;
  localparam logic [2:0] STEP_A2_LO  = 3'd6;
  localparam logic [2:0] STEP_DRAIN  = 3'd7;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_CONV  = 6'b000100,
    ST_TRUNC = 6'b001000,
    ST_GAIN  = 6'b010000,
    ST_SCALE = 6'b100000
  } state_e;

  cfg_t cfg;

  state_e                      state_q, state_d;
  logic [2:0]                  step_q, step_d;
  logic [2:0]                  prev_step;

  logic signed [SAMPLE_W-1:0]  x_q, x1_q, x2_q;
  logic signed [HIST_W-1:0]    y1_q, y2_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [YI_W-1:0]      yi_q;
  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  speaker_q;

  logic                        in_accept;
  logic                        out_free;
  logic signed [SAMPLE_W:0]    lr_sum;
  logic signed [SAMPLE_W:0]    lr_adj;
  logic signed [SAMPLE_W-1:0]  x_new;

  logic                        mul_en;
  logic signed [COEF_W-1:0]    a_op;
  logic signed [MUL_B_W-1:0]   b_op;
  logic signed [PROD_W-1:0]    prod_full;

  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [ACC_W-1:0]     term;

  logic signed [WIDE_W-1:0]    acc_wide;
  logic signed [WIDE_W-1:0]    y_full;
  logic signed [HIST_W-1:0]    y_sat;
  logic signed [HIST_W-1:0]    y_bias;
  logic [GAIN_W-1:0]           gain;
  logic signed [PROD_W-1:0]    s_bias;
  logic signed [PROD_W-1:0]    s_full;
  logic signed [SAMPLE_W-1:0]  s_sat;

  ahgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake
  assign in_stall_o       = (state_q != ST_IDLE);
  assign in_accept        = in_valid_i && !in_stall_o;
  assign out_free         = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign speaker_sample_o = speaker_q;

  // Pick the filter input: stereo average truncates toward zero
  assign lr_sum = (SAMPLE_W+1)'(left_sample_i) + (SAMPLE_W+1)'(right_sample_i);
  assign lr_adj = lr_sum + (SAMPLE_W+1)'({1'b0, lr_sum[SAMPLE_W]});
  assign x_new  = cfg.source_stereo ? lr_adj[SAMPLE_W:1] : left_sample_i;

  // Select operands of the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    a_op   = '0;
    b_op   = '0;
    if (state_q == ST_MAC && step_q != STEP_DRAIN) begin
      mul_en = 1'b1;
      case (step_q)
        STEP_B0_X: begin
          a_op = cfg.coef_b0;
          b_op = MUL_B_W'(x_q);
        end
        STEP_B1_X1: begin
          a_op = cfg.coef_b1;
          b_op = MUL_B_W'(x1_q);
        end
        STEP_B0_X2: begin
          a_op = cfg.coef_b0;
          b_op = MUL_B_W'(x2_q);
        end
        STEP_A1_HI: begin
          a_op = cfg.coef_a1;
          b_op = MUL_B_W'($signed(y1_q[HIST_W-1:HIST_FRAC]));
        end
        STEP_A1_LO: begin
          a_op = cfg.coef_a1;
          b_op = $signed({(MUL_B_W-HIST_FRAC)'(0), y1_q[HIST_FRAC-1:0]});
        end
        STEP_A2_HI: begin
          a_op = cfg.coef_a2;
          b_op = MUL_B_W'($signed(y2_q[HIST_W-1:HIST_FRAC]));
        end
        STEP_A2_LO: begin
          a_op = cfg.coef_a2;
          b_op = $signed({(MUL_B_W-HIST_FRAC)'(0), y2_q[HIST_FRAC-1:0]});
        end
        default: begin
          a_op = '0;
          b_op = '0;
        end
      endcase
    end else if (state_q == ST_GAIN) begin
      mul_en = 1'b1;
      a_op   = $signed({(COEF_W-GAIN_W)'(0), gain});
      b_op   = MUL_B_W'(yi_q);
    end
  end

  assign prod_full = $signed({{(PROD_W-COEF_W){a_op[COEF_W-1]}}, a_op})
                   * $signed({{(PROD_W-MUL_B_W){b_op[MUL_B_W-1]}}, b_op});

  // Term of the product registered in the previous step; low-half feedback floors by 2^16
  assign prev_step = step_q - 3'd1;
  assign prod_ext  = ACC_W'(prod_q);

  always_comb begin
    case (prev_step) inside
      STEP_B0_X, STEP_B1_X1, STEP_B0_X2: term = prod_ext;
      STEP_A1_HI, STEP_A2_HI:            term = -prod_ext;
      STEP_A1_LO, STEP_A2_LO:            term = -(prod_ext >>> HIST_FRAC);
      default:                           term = '0;
    endcase
  end

  // Bring the sum to Q.16 (floor) and saturate to the history range
  assign acc_wide = WIDE_W'(acc_q);
  assign y_full   = (acc_wide >>> SHR) <<< SHL;

  always_comb begin
    if (y_full > HIST_MAX) begin
      y_sat = HIST_MAX[HIST_W-1:0];
    end else if (y_full < HIST_MIN) begin
      y_sat = HIST_MIN[HIST_W-1:0];
    end else begin
      y_sat = y_full[HIST_W-1:0];
    end
  end

  // Integer part of the newest output, truncated toward zero
  assign y_bias = y1_q + (y1_q[HIST_W-1] ? HIST_W'({HIST_FRAC{1'b1}}) : '0);
  assign gain   = gain_of(cfg.volume_pct);

  // Scale down by 256 toward zero and clamp to 16 bits
  assign s_bias = prod_q + (prod_q[PROD_W-1] ? PROD_W'(8'hFF) : '0);
  assign s_full = s_bias >>> 8;

  always_comb begin
    if (s_full > SAMP_MAX) begin
      s_sat = SAMP_MAX[SAMPLE_W-1:0];
    end else if (s_full < SAMP_MIN) begin
      s_sat = SAMP_MIN[SAMPLE_W-1:0];
    end else begin
      s_sat = s_full[SAMPLE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_MAC;
          step_d  = STEP_B0_X;
        end
      end
      ST_MAC: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_DRAIN) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV:  state_d = ST_TRUNC;
      ST_TRUNC: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_SCALE;
      ST_SCALE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_B0_X;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Filter history: shift once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (state_q == ST_CONV) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_sat;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= x_new;
    end
    if (mul_en) begin
      prod_q <= prod_full;
    end
    if (in_accept) begin
      acc_q <= '0;
    end else if (state_q == ST_MAC && step_q != STEP_B0_X) begin
      acc_q <= acc_q + term;
    end
    if (state_q == ST_TRUNC) begin
      yi_q <= y_bias[HIST_W-1:HIST_FRAC];
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_SCALE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE && out_free) begin
      speaker_q <= s_sat;
    end
  end

  // A new result only comes out of the scale step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SCALE))
    else $error("output valid rose outside the scale step");

  // An accepted item starts the multiply sequence at its first product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_MAC && step_q == STEP_B0_X))
    else $error("accepted item did not start the multiply sequence");

  // History advances by exactly one place per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |=> (x2_q == $past(x1_q) && y2_q == $past(y1_q)))
    else $error("filter history did not shift");

  // A pending result is never overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE && out_valid_q && out_stall_i) |=> (state_q == ST_SCALE))
    else $error("scale step left while output was stalled");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ahgc_pkg::*;

  localparam int  NUM_REGS        = 6;
  localparam int  ITEMS_PER_PHASE = 200;
  localparam int  NUM_PHASES      = 8;
  localparam int  HOLD_CYCLES     = 300;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam int  MAX_REPORTS     = 10;
  localparam int  TAIL_CYCLES     = 30;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
  localparam longint HIST_TOP    = (longint'(1) <<< (HIST_W - 1)) - 1;
  localparam longint HIST_BOTTOM = -HIST_TOP - 1;
  localparam longint SAMPLE_TOP    = 32767;
  localparam longint SAMPLE_BOTTOM = -32768;

  // 100 Hz and 1 kHz high-pass sections, Q4.28
  localparam logic signed [COEF_W-1:0] HP100_B0 = 265744758;
  localparam logic signed [COEF_W-1:0] HP100_B1 = -531489516;
  localparam logic signed [COEF_W-1:0] HP100_A1 = -531462474;
  localparam logic signed [COEF_W-1:0] HP100_A2 = 263080974;
  localparam logic signed [COEF_W-1:0] HP1K_B0  = 244702273;
  localparam logic signed [COEF_W-1:0] HP1K_B1  = -489404546;
  localparam logic signed [COEF_W-1:0] HP1K_A1  = -487300815;
  localparam logic signed [COEF_W-1:0] HP1K_A2  = 223071475;

  typedef struct {
    int                          setting;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  right;
    bit                          known;
    logic signed [SAMPLE_W-1:0]  want;
  } frame_row_t;

  logic                        clk_i;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  left_sample_i  = '0;
  logic signed [SAMPLE_W-1:0]  right_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic signed [SAMPLE_W-1:0]  speaker_sample_o;
  logic                        psel           = 1'b0;
  logic                        penable        = 1'b0;
  logic                        pwrite         = 1'b0;
  logic [ADDR_W-1:0]           paddr          = '0;
  logic [DATA_W-1:0]           pwdata         = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  // Filter state and register copy for prediction
  cfg_t   model_cfg;
  int     hist_x1, hist_x2;
  longint hist_y1, hist_y2;

  logic signed [SAMPLE_W-1:0] pending_speaker [$];
  logic signed [SAMPLE_W-1:0] want_sample;
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  int     tx_idle_pct    = 0;
  int     rx_stall_pct   = 0;
  bit     hold_go        = 1'b0;
  bit     hold_off       = 1'b0;

  frame_row_t directed_rows [23];
  cfg_t       directed_settings [4];

  audio_highpass_gain_clamp_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .left_sample_i    (left_sample_i),
    .right_sample_i   (right_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .speaker_sample_o (speaker_sample_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endfunction

  function automatic cfg_t make_settings(input logic signed [COEF_W-1:0] b0, b1, a1, a2,
                                         input int vol, input bit stereo);
    cfg_t c;
    c.coef_b0       = b0;
    c.coef_b1       = b1;
    c.coef_a1       = a1;
    c.coef_a2       = a2;
    c.volume_pct    = VOL_W'(vol);
    c.source_stereo = stereo;
    return c;
  endfunction

  // Tame draws keep the poles mostly near the unit circle; wild draws span the full range
  function automatic cfg_t random_settings(input bit tame);
    cfg_t c;
    if (tame) begin
      c = make_settings(int'($urandom_range(1 << 29)) - (1 << 28),
                        int'($urandom_range(1 << 30)) - (1 << 29),
                        int'($urandom_range(1 << 30)) - (1 << 29) - (1 << 28),
                        int'($urandom_range(255000000)),
                        $urandom_range(127), $urandom_range(1));
    end else begin
      c = make_settings($urandom, $urandom, $urandom, $urandom,
                        $urandom_range(127), $urandom_range(1));
    end
    return c;
  endfunction

  // Feedback product: coefficient (Q.F) times history (Q.16), floored into Q.F
  function automatic longint hist_product(input longint coef, input longint y);
    longint hi, lo;
    hi = y >>> HIST_FRAC;
    lo = y - (hi <<< HIST_FRAC);
    return coef * hi + ((coef * lo) >>> HIST_FRAC);
  endfunction

  // Run one frame through the biquad, gain and clamp; advance the filter history
  function automatic logic signed [SAMPLE_W-1:0] filter_frame(
      input logic signed [SAMPLE_W-1:0] l, r);
    int     x;
    longint b0, b1, a1, a2, acc, y, yi, gain, s;
    b0 = longint'($signed(model_cfg.coef_b0));
    b1 = longint'($signed(model_cfg.coef_b1));
    a1 = longint'($signed(model_cfg.coef_a1));
    a2 = longint'($signed(model_cfg.coef_a2));
    x  = model_cfg.source_stereo ? (int'(l) + int'(r)) / 2 : int'(l);
    acc = b0 * x + b1 * hist_x1 + b0 * hist_x2
        - hist_product(a1, hist_y1) - hist_product(a2, hist_y2);
    if (COEF_FRAC_BITS >= HIST_FRAC) y = acc >>> (COEF_FRAC_BITS - HIST_FRAC);
    else y = acc <<< (HIST_FRAC - COEF_FRAC_BITS);
    if (y > HIST_TOP) y = HIST_TOP;
    if (y < HIST_BOTTOM) y = HIST_BOTTOM;
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = y;
    yi   = y / (longint'(1) <<< HIST_FRAC);
    gain = longint'(model_cfg.volume_pct) * 256 / 100;
    s    = (yi * gain) / 256;
    if (s > SAMPLE_TOP) s = SAMPLE_TOP;
    if (s < SAMPLE_BOTTOM) s = SAMPLE_BOTTOM;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(input int idx);
    return ADDR_W'(4 * idx);
  endfunction

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write every register, poke the unmapped slot, then read all back
  task automatic load_settings(input cfg_t c);
    logic [DATA_W-1:0] want [NUM_REGS];
    logic [DATA_W-1:0] got;
    want[REG_COEF_B0] = c.coef_b0;
    want[REG_COEF_B1] = c.coef_b1;
    want[REG_COEF_A1] = c.coef_a1;
    want[REG_COEF_A2] = c.coef_a2;
    want[REG_VOLUME]  = DATA_W'(c.volume_pct);
    want[REG_STEREO]  = DATA_W'(c.source_stereo);
    for (int i = 0; i < NUM_REGS; i++) apb_write(reg_addr(i), want[i]);
    apb_write(reg_addr(NUM_REGS), $urandom);
    model_cfg = c;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_read(reg_addr(i), got);
      if (got !== want[i])
        flag_mismatch($sformatf("register %0d readback: expected %h, got %h", i, want[i], got));
    end
  endtask

  // Drop valid and wait until every expected sample has come out
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_speaker.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic offer_frame(input logic signed [SAMPLE_W-1:0] l, r,
                             input bit known, input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = filter_frame(l, r);
    pending_speaker.push_back(known ? want : predicted);
  endtask

  // Receiver stall: random, or forced high during the hold-off
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < rx_stall_pct);
  end

  // Hold off the output long enough to back up the input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Compare each taken sample with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_speaker.size() == 0) begin
        flag_mismatch($sformatf("unexpected speaker sample %0d", speaker_sample_o));
      end else begin
        want_sample = pending_speaker.pop_front();
        if (speaker_sample_o !== want_sample)
          flag_mismatch($sformatf("speaker sample: expected %0d, got %0d",
                                  want_sample, speaker_sample_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d samples outstanding", pending_speaker.size());
      $display("** audio_highpass_gain_clamp_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] l, r;
    int   pick;
    cfg_t phase_cfg;

    model_cfg = make_settings(COEF_ONE, '0, '0, '0, VOL_RESET, 1'b0);
    hist_x1 = 0;
    hist_x2 = 0;
    hist_y1 = 0;
    hist_y2 = 0;
    l = '0;
    r = '0;

    directed_settings[0] = make_settings(COEF_ONE, '0, '0, '0, 0, 1'b0);
    directed_settings[1] = make_settings(COEF_ONE, '0, '0, '0, 100, 1'b1);
    directed_settings[2] = make_settings(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 127, 1'b1);
    directed_settings[3] = make_settings(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, 5, 1'b0);

    // Reset defaults first: b0 = 1.0 with b2 = b0, so y = x + x2; then volume 0,
    // stereo averaging, and coefficient extremes that saturate the history
    directed_rows = '{
      '{0,  32767, -32768, 1,  27775},
      '{0, -32768,  32767, 1, -27776},
      '{0,  32767,      0, 1,  32767},
      '{0, -32768,      0, 1, -32768},
      '{0,      0,     -1, 0,      0},
      '{0,      1,      1, 0,      0},
      '{0,     -1,     -1, 0,      0},
      '{1,  32767,  32767, 1,      0},
      '{0, -32768, -32768, 1,      0},
      '{2,  32767,  32767, 0,      0},
      '{0, -32768, -32768, 0,      0},
      '{0,     -1,      0, 0,      0},
      '{0,     -3,      0, 0,      0},
      '{0,  32767, -32768, 0,      0},
      '{0, -32768,  32767, 0,      0},
      '{3,  32767,  32767, 0,      0},
      '{0, -32768, -32768, 0,      0},
      '{0,  32767,  32767, 0,      0},
      '{0,      0,      0, 0,      0},
      '{4, -32768,      0, 0,      0},
      '{0,  32767,     -1, 0,      0},
      '{0, -32768,  32767, 0,      0},
      '{0,  12345, -12345, 0,      0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != 0) begin
        settle_idle();
        load_settings(directed_settings[directed_rows[i].setting - 1]);
      end
      offer_frame(directed_rows[i].left, directed_rows[i].right,
                  directed_rows[i].known, directed_rows[i].want);
    end

    // Random phases, cycling through the idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      case (p)
        0: phase_cfg = make_settings(HP100_B0, HP100_B1, HP100_A1, HP100_A2, 85, 1'b0);
        1: phase_cfg = make_settings(HP100_B0, HP100_B1, HP100_A1, HP100_A2, 100, 1'b1);
        2: phase_cfg = make_settings(HP1K_B0, HP1K_B1, HP1K_A1, HP1K_A2, 5, 1'b1);
        3: phase_cfg = random_settings(1'b0);
        4: phase_cfg = make_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 127, 1'b1);
        5: phase_cfg = make_settings(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 100, 1'b0);
        6: phase_cfg = make_settings(HP1K_B0, HP1K_B1, HP1K_A1, HP1K_A2, 100, 1'b0);
        default: phase_cfg = random_settings(1'b1);
      endcase
      load_settings(phase_cfg);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      if (p == 2) hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mostly full-scale noise, some quiet passages, some held levels
        pick = $urandom_range(99);
        if (pick < 60) begin
          l = SAMPLE_W'($urandom);
          r = SAMPLE_W'($urandom);
        end else if (pick < 80) begin
          l = SAMPLE_W'(int'($urandom_range(600)) - 300);
          r = SAMPLE_W'(int'($urandom_range(600)) - 300);
        end
        offer_frame(l, r, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** audio_highpass_gain_clamp_core: PASSED **");
    end else begin
      $display("** audio_highpass_gain_clamp_core: FAILED **");
    end
    $finish;
  end

endmodule
